FILE: hdl/generational_slot_allocator_macros.svh
// Assertion macros for the slot allocator.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define GSA_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("gsa check failed");

// Next-cycle implication.
`define GSA_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gsa check failed");

`endif

FILE: hdl/gsa_pkg.sv
package gsa_pkg;

  localparam int unsigned MaxClsW  = 8;
  localparam int unsigned MaxSlotW = 6;

  typedef enum logic [0:0] {
    ReqAlloc = 1'b0,
    ReqFree  = 1'b1
  } req_e;

  typedef struct packed {
    req_e        req_type;
    logic [7:0]  event_class;
    logic [31:0] handle_generation;
    logic [15:0] handle_slot;
    logic [15:0] handle_class;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] out_generation;
    logic [15:0] out_slot;
    logic [15:0] out_class;
    logic [3:0]  class_count;
  } rsp_t;

  typedef struct packed {
    logic                en;
    logic                set;
    logic [MaxClsW-1:0]  cls;
    logic [MaxSlotW-1:0] slot;
  } tbl_upd_t;

endpackage

FILE: hdl/gsa_ram.sv
module gsa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/gsa_slot_table.sv
module gsa_slot_table #(
  parameter int unsigned NUM_CLASSES     = 16,
  parameter int unsigned SLOTS_PER_CLASS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  gsa_pkg::tbl_upd_t        upd_i,
  input  logic [(NUM_CLASSES > 1 ? $clog2(NUM_CLASSES) : 1)-1:0] dec_cls_i,
  output logic [SLOTS_PER_CLASS-1:0] dec_row_o,
  input  logic [(NUM_CLASSES > 1 ? $clog2(NUM_CLASSES) : 1)-1:0] cur_cls_i,
  input  logic [(SLOTS_PER_CLASS > 1 ? $clog2(SLOTS_PER_CLASS) : 1)-1:0] cur_slot_i,
  output logic                     cur_active_o,
  output logic                     cur_gvalid_o,
  output logic [$clog2(SLOTS_PER_CLASS + 1)-1:0] cur_count_o
);

  localparam int unsigned ClsW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned SlotW = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
  localparam int unsigned CntW  = $clog2(SLOTS_PER_CLASS + 1);

  logic [SLOTS_PER_CLASS-1:0] act_q  [NUM_CLASSES];
  logic [SLOTS_PER_CLASS-1:0] act_d  [NUM_CLASSES];
  logic [SLOTS_PER_CLASS-1:0] gval_q [NUM_CLASSES];
  logic [ClsW-1:0]            upd_cls;
  logic [SlotW-1:0]           upd_slot;
  logic [SLOTS_PER_CLASS-1:0] cur_row;
  logic [CntW-1:0]            cnt;

  assign upd_cls  = upd_i.cls[ClsW-1:0];
  assign upd_slot = upd_i.slot[SlotW-1:0];

  always_comb begin
    act_d = act_q;
    if (upd_i.en) begin
      act_d[upd_cls][upd_slot] = upd_i.set;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= '{default: '0};
      gval_q <= '{default: '0};
    end else begin
      act_q <= act_d;
      if (upd_i.en && upd_i.set) begin
        gval_q[upd_cls][upd_slot] <= 1'b1;
      end
    end
  end

  assign dec_row_o    = act_d[dec_cls_i];
  assign cur_active_o = act_q[cur_cls_i][cur_slot_i];
  assign cur_gvalid_o = gval_q[cur_cls_i][cur_slot_i];
  assign cur_row      = act_d[cur_cls_i];

  always_comb begin
    cnt = '0;
    for (int i = 0; i < SLOTS_PER_CLASS; i++) begin
      cnt = cnt + CntW'(cur_row[i]);
    end
  end

  assign cur_count_o = cnt;

endmodule

FILE: hdl/generational_slot_allocator.sv
// Each item is held in the s1 register, then its result in the output register (rsp_o).
// Throughput: one item per cycle unless the output stalls; set by the single pass through the
// slot bitmap and one registered read of the generation RAM per item.
// Reset clears the slot bitmap, generation valid bits and pipeline valids.
// The generation RAM is not swept; an entry never written reads as zero.
`include "generational_slot_allocator_macros.svh"

module generational_slot_allocator #(
  parameter int unsigned NUM_CLASSES     = 16,
  parameter int unsigned SLOTS_PER_CLASS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  gsa_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output gsa_pkg::rsp_t rsp_o
);

  localparam int unsigned ClsW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned SlotW   = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
  localparam int unsigned Entries = NUM_CLASSES * SLOTS_PER_CLASS;
  localparam int unsigned IdxW    = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CntW    = $clog2(SLOTS_PER_CLASS + 1);

  typedef struct packed {
    logic             alloc;
    logic             cls_ok;
    logic             ok;
    logic [ClsW-1:0]  cls;
    logic [SlotW-1:0] slot;
    logic [IdxW-1:0]  idx;
    logic [31:0]      hgen;
  } stage_t;

  logic                       accept;
  logic                       s1_go;
  logic                       s1_v_q, s1_v_d;
  stage_t                     s1_q, s1_d;
  logic                       out_v_q, out_v_d;
  gsa_pkg::rsp_t              out_q, out_d;
  logic                       fwd_q, fwd_d;
  logic [31:0]                wdata_q;

  logic [ClsW-1:0]            dec_cls;
  logic                       dec_cls_ok;
  logic [SLOTS_PER_CLASS-1:0] dec_row;
  logic [SlotW-1:0]           free_slot;
  logic                       hzero;
  logic                       hslot_ok;

  logic [31:0]                ram_rdata;
  logic                       cur_active;
  logic                       cur_gvalid;
  logic [CntW-1:0]            cur_count;
  logic [31:0]                gen_cur;
  logic [31:0]                gen_new;
  logic                       success;
  logic                       wr_en;
  gsa_pkg::tbl_upd_t          upd;

  assign s1_go       = s1_v_q && (!out_v_q || !rsp_stall_i);
  assign req_stall_o = s1_v_q && !s1_go;
  assign accept      = req_valid_i && !req_stall_o;

  always_comb begin
    free_slot = '0;
    for (int i = SLOTS_PER_CLASS - 1; i >= 0; i--) begin
      if (!dec_row[i]) begin
        free_slot = SlotW'(i);
      end
    end
  end

  assign hzero    = (req_i.handle_generation == 32'd0) && (req_i.handle_slot == 16'd0)
                    && (req_i.handle_class == 16'd0);
  assign hslot_ok = 32'(req_i.handle_slot) < SLOTS_PER_CLASS;

  always_comb begin
    if (req_i.req_type == gsa_pkg::ReqAlloc) begin
      dec_cls_ok = 32'(req_i.event_class) < NUM_CLASSES;
      dec_cls    = dec_cls_ok ? req_i.event_class[ClsW-1:0] : '0;
    end else begin
      dec_cls_ok = 32'(req_i.handle_class) < NUM_CLASSES;
      dec_cls    = dec_cls_ok ? req_i.handle_class[ClsW-1:0] : '0;
    end
  end

  always_comb begin
    s1_d        = s1_q;
    s1_d.alloc  = (req_i.req_type == gsa_pkg::ReqAlloc);
    s1_d.hgen   = req_i.handle_generation;
    s1_d.cls_ok = dec_cls_ok;
    s1_d.cls    = dec_cls;
    if (s1_d.alloc) begin
      s1_d.ok   = dec_cls_ok && !(&dec_row);
      s1_d.slot = free_slot;
    end else begin
      s1_d.ok   = dec_cls_ok && hslot_ok && !hzero;
      s1_d.slot = hslot_ok ? req_i.handle_slot[SlotW-1:0] : '0;
    end
    s1_d.idx = IdxW'(32'(dec_cls) * SLOTS_PER_CLASS + 32'(s1_d.slot));
  end

  gsa_slot_table #(
    .NUM_CLASSES    (NUM_CLASSES),
    .SLOTS_PER_CLASS(SLOTS_PER_CLASS)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (upd),
    .dec_cls_i   (dec_cls),
    .dec_row_o   (dec_row),
    .cur_cls_i   (s1_q.cls),
    .cur_slot_i  (s1_q.slot),
    .cur_active_o(cur_active),
    .cur_gvalid_o(cur_gvalid),
    .cur_count_o (cur_count)
  );

  gsa_ram #(
    .Width(32),
    .Depth(Entries)
  ) u_gen_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(s1_q.idx),
    .wdata_i(gen_new),
    .re_i   (accept),
    .raddr_i(s1_d.idx),
    .rdata_o(ram_rdata)
  );

  assign gen_cur = fwd_q ? wdata_q : (cur_gvalid ? ram_rdata : 32'd0);
  assign gen_new = gen_cur + 32'd1;
  assign success = s1_q.alloc ? s1_q.ok
                              : (s1_q.ok && cur_active && (gen_cur == s1_q.hgen));
  assign wr_en   = s1_go && s1_q.alloc && s1_q.ok;

  always_comb begin
    upd      = '0;
    upd.en   = s1_go && success;
    upd.set  = s1_q.alloc;
    upd.cls  = gsa_pkg::MaxClsW'(s1_q.cls);
    upd.slot = gsa_pkg::MaxSlotW'(s1_q.slot);
  end

  always_comb begin
    out_d             = '0;
    out_d.accepted    = success;
    out_d.class_count = s1_q.cls_ok ? 4'(cur_count) : 4'd0;
    if (s1_q.alloc && success) begin
      out_d.out_generation = gen_new;
      out_d.out_slot       = 16'(s1_q.slot);
      out_d.out_class      = 16'(s1_q.cls);
    end
  end

  assign fwd_d   = accept ? (wr_en && (s1_d.idx == s1_q.idx)) : (s1_go ? 1'b0 : fwd_q);
  assign s1_v_d  = accept ? 1'b1 : (s1_go ? 1'b0 : s1_v_q);
  assign out_v_d = s1_go ? 1'b1 : (out_v_q && rsp_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
      fwd_q   <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (s1_go) begin
      out_q <= out_d;
    end
    if (wr_en) begin
      wdata_q <= gen_new;
    end
  end

  assign rsp_valid_o = out_v_q;
  assign rsp_o       = out_q;

  `GSA_ASSERT_NOW(a_stall_needs_full_out, clk_i, rst_ni, req_stall_o, out_v_q && s1_v_q)
  `GSA_ASSERT_NOW(a_fwd_needs_item, clk_i, rst_ni, fwd_q, s1_v_q)
  `GSA_ASSERT_NOW(a_alloc_takes_idle_slot, clk_i, rst_ni, upd.en && upd.set, !cur_active)
  `GSA_ASSERT_NOW(a_free_needs_active_slot, clk_i, rst_ni, upd.en && !upd.set, cur_active)
  `GSA_ASSERT_NEXT(a_go_fills_output, clk_i, rst_ni, s1_go, rsp_valid_o)

endmodule

FILE: tb/sv/generational_slot_allocator_tb.sv
`timescale 1ns / 1ps

module generational_slot_allocator_tb;

  localparam int unsigned NumClasses    = 16;
  localparam int unsigned SlotsPerClass = 8;
  localparam int unsigned NumItems      = 750;
  localparam int unsigned QuietFrom     = 650;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned MaxReports    = 10;

  class handle_table;
    bit            active   [NumClasses][SlotsPerClass];
    bit [31:0]     gen_tbl  [NumClasses][SlotsPerClass];
    bit [3:0]      live_cnt [NumClasses];
    gsa_pkg::rsp_t expected_q [$];
    int unsigned   mismatches;

    function void note_request(gsa_pkg::req_t r);
      gsa_pkg::rsp_t e;
      int            c;
      int            s;
      int            pick;
      e    = '0;
      pick = -1;
      if (r.req_type == gsa_pkg::ReqAlloc) begin
        if (r.event_class < NumClasses) begin
          c = r.event_class;
          for (s = SlotsPerClass - 1; s >= 0; s--) begin
            if (!active[c][s]) pick = s;
          end
          if (pick < 0) begin
            e.class_count = live_cnt[c];
          end else begin
            gen_tbl[c][pick] = gen_tbl[c][pick] + 32'd1;
            active[c][pick]  = 1'b1;
            live_cnt[c]      = live_cnt[c] + 4'd1;
            e.accepted       = 1'b1;
            e.out_generation = gen_tbl[c][pick];
            e.out_slot       = 16'(pick);
            e.out_class      = 16'(c);
            e.class_count    = live_cnt[c];
          end
        end
      end else if (r.handle_class < NumClasses) begin
        c = r.handle_class;
        e.class_count = live_cnt[c];
        if ({r.handle_generation, r.handle_slot, r.handle_class} != '0 &&
            r.handle_slot < SlotsPerClass) begin
          s = r.handle_slot;
          if (active[c][s] && gen_tbl[c][s] == r.handle_generation) begin
            active[c][s] = 1'b0;
            if (live_cnt[c] != 4'd0) live_cnt[c] = live_cnt[c] - 4'd1;
            e.accepted    = 1'b1;
            e.class_count = live_cnt[c];
          end
        end
      end
      expected_q.push_back(e);
    endfunction

    function void report(string what, gsa_pkg::rsp_t e, gsa_pkg::rsp_t g);
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("%s: expected %0d %0h %0d %0d %0d, got %0d %0h %0d %0d %0d",
                 what, e.accepted, e.out_generation, e.out_slot, e.out_class, e.class_count,
                 g.accepted, g.out_generation, g.out_slot, g.out_class, g.class_count);
      end
    endfunction

    function void check_response(gsa_pkg::rsp_t got);
      gsa_pkg::rsp_t want;
      bit            bad;
      if (expected_q.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = expected_q.pop_front();
      bad  = (got.accepted !== want.accepted) ||
             (got.out_generation !== want.out_generation) ||
             (got.out_slot !== want.out_slot) ||
             (got.out_class !== want.out_class) ||
             (got.class_count !== want.class_count);
      if (bad) report("result mismatch", want, got);
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni      = 1'b0;
  logic          req_valid_i = 1'b0;
  logic          req_stall_o;
  gsa_pkg::req_t req_i       = '0;
  logic          rsp_valid_o;
  logic          rsp_stall_i = 1'b0;
  gsa_pkg::rsp_t rsp_o;
  bit            quiet       = 1'b0;
  int unsigned   cycles      = 0;
  handle_table   alloc_model = new;

  generational_slot_allocator #(
    .NUM_CLASSES    (NumClasses),
    .SLOTS_PER_CLASS(SlotsPerClass)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_stall_o(req_stall_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_stall_i(rsp_stall_i),
    .rsp_o      (rsp_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL generational_slot_allocator");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && !rsp_stall_i) alloc_model.check_response(rsp_o);
  end

  initial begin
    int unsigned left;
    int unsigned pct;
    int unsigned phase;
    left  = 0;
    pct   = 0;
    phase = 0;
    forever begin
      @(posedge clk_i);
      if (phase % 64 == 0) begin
        case ($urandom_range(2))
          0: pct = 0;
          1: pct = 15;
          default: pct = 40;
        endcase
      end
      phase++;
      if (left != 0) begin
        left--;
      end else if (rsp_stall_i) begin
        rsp_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(99) < pct) begin
        rsp_stall_i <= 1'b1;
        left = $urandom_range(3, 1) - 1;
      end
    end
  end

  function automatic gsa_pkg::req_t alloc_req(int c);
    gsa_pkg::req_t r;
    r.req_type          = gsa_pkg::ReqAlloc;
    r.event_class       = 8'(c);
    r.handle_generation = $urandom;
    r.handle_slot       = 16'($urandom);
    r.handle_class      = 16'($urandom);
    return r;
  endfunction

  function automatic gsa_pkg::req_t free_req(int c, int s, bit [31:0] g);
    gsa_pkg::req_t r;
    r.req_type          = gsa_pkg::ReqFree;
    r.event_class       = 8'($urandom);
    r.handle_generation = g;
    r.handle_slot       = 16'(s);
    r.handle_class      = 16'(c);
    return r;
  endfunction

  function automatic gsa_pkg::req_t next_item();
    gsa_pkg::req_t r;
    int unsigned   roll;
    int            c;
    int            s;
    int            n;
    int            k;
    roll = $urandom_range(99);
    r    = alloc_req(($urandom_range(3) != 0) ? $urandom_range(2)
                                              : $urandom_range(NumClasses - 1));
    if (roll < 40) begin
      return r;
    end else if (roll < 45) begin
      r = alloc_req($urandom_range(255, NumClasses));
    end else if (roll < 80) begin
      n = 0;
      foreach (alloc_model.active[i, j]) if (alloc_model.active[i][j]) n++;
      if (n != 0) begin
        k = $urandom_range(n - 1);
        foreach (alloc_model.active[i, j]) begin
          if (alloc_model.active[i][j]) begin
            if (k == 0) r = free_req(i, j, alloc_model.gen_tbl[i][j]);
            k--;
          end
        end
      end
    end else if (roll < 88) begin
      c = $urandom_range(NumClasses - 1);
      s = $urandom_range(SlotsPerClass - 1);
      r = free_req(c, s,
                   alloc_model.gen_tbl[c][s] + (($urandom_range(1) != 0) ? 32'd0 : 32'd1));
    end else if (roll < 92) begin
      r = free_req($urandom_range(NumClasses - 1), $urandom_range(65535, SlotsPerClass), $urandom);
    end else if (roll < 96) begin
      r = free_req($urandom_range(65535, NumClasses), $urandom_range(SlotsPerClass - 1), $urandom);
    end else begin
      r.req_type    = gsa_pkg::req_e'($urandom_range(1));
      r.event_class = 8'($urandom);
    end
    return r;
  endfunction

  task automatic send_item(gsa_pkg::req_t r);
    req_i       <= r;
    req_valid_i <= 1'b1;
    @(posedge clk_i);
    while (req_stall_o !== 1'b0) @(posedge clk_i);
    alloc_model.note_request(r);
  endtask

  task automatic push_item(gsa_pkg::req_t r);
    send_item(r);
    if (!quiet && $urandom_range(99) < 25) begin
      req_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    req_valid_i <= 1'b0;
    do @(posedge clk_i); while (alloc_model.expected_q.size() != 0);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_item(free_req(0, 0, 32'd0));
    repeat (SlotsPerClass + 1) push_item(alloc_req(0));
    push_item(free_req(0, 3, 32'd1));
    push_item(free_req(0, 3, 32'd1));
    push_item(alloc_req(0));
    push_item(free_req(0, 3, 32'd1));
    push_item(free_req(0, 3, 32'd2));
    push_item(alloc_req(NumClasses - 1));
    push_item(alloc_req(NumClasses));
    push_item(alloc_req(255));
    push_item(free_req(NumClasses, 0, 32'd1));
    push_item(free_req(16'hFFFF, 0, 32'd1));
    push_item(free_req(NumClasses - 1, SlotsPerClass, 32'd1));
    push_item(free_req(NumClasses - 1, 16'hFFFF, 32'd1));
    push_item(free_req(NumClasses - 1, 0, 32'hFFFF_FFFF));
    push_item(free_req(NumClasses - 1, 0, 32'd1));
    drain();

    for (int i = 0; i < NumItems; i++) begin
      if (i == QuietFrom) quiet = 1'b1;
      if (i == NumItems / 2) drain();
      push_item(next_item());
    end
    drain();
    repeat (10) @(posedge clk_i);

    if (alloc_model.mismatches == 0 && alloc_model.expected_q.size() == 0) begin
      $display("PASS generational_slot_allocator");
    end else begin
      $display("FAIL generational_slot_allocator");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/gsa_pkg.sv
hdl/gsa_ram.sv
hdl/gsa_slot_table.sv
hdl/generational_slot_allocator.sv
tb/sv/generational_slot_allocator_tb.sv
